// ===== hdl/lpg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types and constants of the line pixel generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

    localparam int COORD_BITS  = 12;
    localparam int COLOR_BITS  = 24;
    localparam int TWICE_BITS  = COORD_BITS + 2;
    localparam int ERR_BITS    = COORD_BITS + 3;
    localparam int QUEUE_DEPTH = 2;

    // request command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
        logic [COLOR_BITS-1:0] color;
    } lpg_req_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  last;
    } lpg_pix_t;

    // classified request, as held in the queue
    typedef struct packed {
        logic                  is_start;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
        logic [COLOR_BITS-1:0] color;
        logic [COORD_BITS-1:0] major;
        logic [COORD_BITS-1:0] minor;
        logic                  x_major;
        logic                  x_neg;
        logic                  y_neg;
        logic                  single;
    } lpg_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } lpg_qstat_t;

endpackage
`default_nettype wire

// ===== hdl/lpg_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpg_front
// Takes requests and classifies start requests into octant, major and minor.
// ----------------------------------------------------------------------------
module lpg_front (
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire lpg_pkg::lpg_req_t req,
    input  wire lpg_pkg::lpg_qstat_t qstat,
    output logic                   push,
    output lpg_pkg::lpg_cmd_t      entry
);
    import lpg_pkg::*;

    logic                  x_neg;
    logic                  y_neg;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic                  x_major;

    assign req_stall = qstat.full;
    assign push      = req_valid && !qstat.full;

    always_comb
    begin
        x_neg   = req.end_x < req.start_x;
        y_neg   = req.end_y < req.start_y;
        adx     = x_neg ? (req.start_x - req.end_x) : (req.end_x - req.start_x);
        ady     = y_neg ? (req.start_y - req.end_y) : (req.end_y - req.start_y);
        // equal lengths: x is the major axis
        x_major = adx >= ady;

        entry.is_start = (req.cmd == CMD_START);
        entry.sx       = req.start_x;
        entry.sy       = req.start_y;
        entry.ex       = req.end_x;
        entry.ey       = req.end_y;
        entry.color    = req.color;
        entry.major    = x_major ? adx : ady;
        entry.minor    = x_major ? ady : adx;
        entry.x_major  = x_major;
        entry.x_neg    = x_neg;
        entry.y_neg    = y_neg;
        entry.single   = (entry.major == '0);
    end

endmodule
`default_nettype wire

// ===== hdl/lpg_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpg_queue
// Small FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module lpg_queue #(
    parameter int DEPTH = lpg_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire lpg_pkg::lpg_cmd_t   wr_entry,
    input  wire logic                pop,
    output lpg_pkg::lpg_cmd_t        head,
    output lpg_pkg::lpg_qstat_t      qstat
);
    import lpg_pkg::*;

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    lpg_cmd_t            slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == CNT_BITS'(DEPTH));
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    // occupancy bookkeeping
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("queue count above depth");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointer gap");
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push without pop did not grow the queue");

endmodule
`default_nettype wire

// ===== hdl/lpg_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpg_back
// Bresenham stepper: one queued request per cycle unless the pixel stalls, pixel output register.
// ----------------------------------------------------------------------------
module lpg_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lpg_pkg::lpg_cmd_t   head,
    input  wire lpg_pkg::lpg_qstat_t qstat,
    output logic                     pop,
    output logic                     pix_valid,
    input  wire logic                pix_stall,
    output lpg_pkg::lpg_pix_t        pix
);
    import lpg_pkg::*;

    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0] target_x_reg, target_x_next;
    logic [COORD_BITS-1:0] target_y_reg, target_y_next;
    logic [ERR_BITS-1:0]   err_reg, err_next;
    logic [TWICE_BITS-1:0] twice_major_reg, twice_major_next;
    logic [TWICE_BITS-1:0] twice_minor_reg, twice_minor_next;
    logic                  x_major_reg, x_major_next;
    logic                  x_neg_reg, x_neg_next;
    logic                  y_neg_reg, y_neg_next;
    logic [COLOR_BITS-1:0] color_reg, color_next;
    logic                  active_reg, active_next;
    logic                  pix_valid_reg, pix_valid_next;
    lpg_pix_t              pix_reg, pix_next;

    logic                  out_free;
    logic [ERR_BITS-1:0]   err_sub;
    logic [ERR_BITS-1:0]   err_add;
    logic                  minor_step;
    logic [COORD_BITS-1:0] x_stepped;
    logic [COORD_BITS-1:0] y_stepped;
    logic                  emit;

    assign out_free  = !pix_valid_reg || !pix_stall;
    assign pop       = !qstat.empty && out_free;
    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    assign err_sub    = err_reg - {1'b0, twice_minor_reg};
    assign err_add    = err_sub + {1'b0, twice_major_reg};
    assign minor_step = err_sub[ERR_BITS-1];
    assign x_stepped  = x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
    assign y_stepped  = y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
    assign emit       = pop && (head.is_start || active_reg);

    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        target_x_next    = target_x_reg;
        target_y_next    = target_y_reg;
        err_next         = err_reg;
        twice_major_next = twice_major_reg;
        twice_minor_next = twice_minor_reg;
        x_major_next     = x_major_reg;
        x_neg_next       = x_neg_reg;
        y_neg_next       = y_neg_reg;
        color_next       = color_reg;
        active_next      = active_reg;
        pix_next         = pix_reg;
        pix_valid_next   = pix_valid_reg && pix_stall;

        if (pop && head.is_start)
        begin
            cur_x_next       = head.sx;
            cur_y_next       = head.sy;
            target_x_next    = head.ex;
            target_y_next    = head.ey;
            err_next         = ERR_BITS'(head.major);
            twice_major_next = {1'b0, head.major, 1'b0};
            twice_minor_next = {1'b0, head.minor, 1'b0};
            x_major_next     = head.x_major;
            x_neg_next       = head.x_neg;
            y_neg_next       = head.y_neg;
            color_next       = head.color;
            active_next      = !head.single;
            pix_next.pixel_x     = head.sx;
            pix_next.pixel_y     = head.sy;
            pix_next.pixel_color = head.color;
            pix_next.last        = head.single;
        end
        else if (pop && active_reg)
        begin
            err_next = minor_step ? err_add : err_sub;
            if (x_major_reg)
            begin
                cur_x_next = x_stepped;
                cur_y_next = minor_step ? y_stepped : cur_y_reg;
                pix_next.last = (x_stepped == target_x_reg);
            end
            else
            begin
                cur_y_next = y_stepped;
                cur_x_next = minor_step ? x_stepped : cur_x_reg;
                pix_next.last = (y_stepped == target_y_reg);
            end
            active_next          = !pix_next.last;
            pix_next.pixel_x     = cur_x_next;
            pix_next.pixel_y     = cur_y_next;
            pix_next.pixel_color = color_reg;
        end

        if (emit)
        begin
            pix_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            target_x_reg    <= '0;
            target_y_reg    <= '0;
            err_reg         <= '0;
            twice_major_reg <= '0;
            twice_minor_reg <= '0;
            x_major_reg     <= 1'b0;
            x_neg_reg       <= 1'b0;
            y_neg_reg       <= 1'b0;
            color_reg       <= '0;
            active_reg      <= 1'b0;
            pix_valid_reg   <= 1'b0;
        end
        else
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            target_x_reg    <= target_x_next;
            target_y_reg    <= target_y_next;
            err_reg         <= err_next;
            twice_major_reg <= twice_major_next;
            twice_minor_reg <= twice_minor_next;
            x_major_reg     <= x_major_next;
            x_neg_reg       <= x_neg_next;
            y_neg_reg       <= y_neg_next;
            color_reg       <= color_next;
            active_reg      <= active_next;
            pix_valid_reg   <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end

    a_err_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> !err_reg[ERR_BITS-1])
        else $error("error term negative during a segment");
    a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.is_start) |=> pix_valid_reg)
        else $error("start request produced no pixel");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (active_reg == !pix_reg.last))
        else $error("segment activity disagrees with last flag");
    a_idle_step_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !head.is_start && !active_reg) |=> ($stable(cur_x_reg) && $stable(cur_y_reg)))
        else $error("step without segment moved the pen");

endmodule
`default_nettype wire

// ===== hdl/line_pixel_generator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// line_pixel_generator_core
// All-octant Bresenham line generator: start requests load a segment and
// emit its first pixel, step requests emit the following pixels.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  ---------------------------------------
//  req      in   req_valid/req_stall  cmd, start_x/y, end_x/y, color
//  pix      out  pix_valid/pix_stall  pixel_x, pixel_y, pixel_color, last
//
//  One request per clock sustained while pix_stall is low; a pixel is
//  presented once its request has passed through the queue and then the
//  stepper's output register (queue write at the accepting edge).
//  The loop that sets the rate is the stepper's error update: one subtract,
//  one conditional add and a coordinate increment per cycle.
//  Reset (rst_n, async, low) empties the queue and leaves no segment active.
//  A stalled pixel holds the stepper; the queue absorbs requests until full,
//  then req_stall rises.
//
module line_pixel_generator_core #(
    parameter int QUEUE_DEPTH = lpg_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire lpg_pkg::lpg_req_t req,
    output logic                   pix_valid,
    input  wire logic              pix_stall,
    output lpg_pkg::lpg_pix_t      pix
);
    import lpg_pkg::*;

    // front -> queue
    logic       push;
    lpg_cmd_t   wr_entry;
    // queue -> back
    lpg_cmd_t   head;
    lpg_qstat_t qstat;
    logic       pop;

    // front: takes requests, works out octant and axis lengths
    lpg_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .qstat     (qstat),
        .push      (push),
        .entry     (wr_entry)
    );

    // decouples request intake from pixel output backpressure
    lpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    // back: segment state, error term, pixel register
    lpg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix)
    );

endmodule
`default_nettype wire
